[rtl/ttrq_pkg.sv]
// ttrq_pkg: shared types and default sizes for the tagged task ring queue
// no dependencies; imported by tagged_task_ring_queue_core
`timescale 1ns / 1ps

package ttrq_pkg;

  // default sizes, overridable on the top level
  localparam int DEPTH_DEFAULT      = 16;
  localparam int SLOT_COUNT_DEFAULT = 8;

  // field widths fixed by the interface
  localparam int MODE_W   = 3;
  localparam int HANDLE_W = 64;
  localparam int ID_W     = 32;
  localparam int WORKER_W = 4;
  localparam int POS_W    = 32;

  // packed widths of the stream payloads, padded to whole bytes
  localparam int IN_DATA_W  = ((2 * HANDLE_W + ID_W + WORKER_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ID_W + 2 * HANDLE_W + 1 + 7) / 8) * 8;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ENQUEUE   = 3'd0,
    MODE_DEQUEUE   = 3'd1,
    MODE_CANCEL    = 3'd2,
    MODE_COMPLETED = 3'd3,
    MODE_READ_FLAG = 3'd4,
    MODE_CLEAR     = 3'd5
  } ttrq_mode_t;

endpackage

[rtl/tagged_task_ring_queue_core.sv]
// tagged_task_ring_queue_core: ring queue of task cells with worker slots
// depends on ttrq_pkg for operation codes, widths and default sizes
`timescale 1ns / 1ps

// Usage: one request transaction on the s_axis channel (operation in tuser,
// routine, argument, task id and worker in tdata) gives exactly one response
// transaction on the m_axis channel (ok in tuser, task fields in tdata).
// Operations: enqueue, dequeue, cancel, completed query, worker flag read and
// clear. Enqueue hands out the complement of the write position as task id.
// The response register is loaded on request acceptance; a request can be
// taken every cycle while the single output register drains. Cell status
// follows from the read and write positions; routine, argument and cancel
// mark live in per-cell memories whose read port prefetches the cell at the
// next read position, with a bypass for a write to that cell.
// Reset zeroes both positions, the worker slots and the output valid, and
// holds s_axis_tready low; cell contents stay undefined until an enqueue.
// When the receiver stalls, the response register holds and the block takes
// no new request until that response is taken (tready follows the free slot
// of the output register, so a request is taken in the cycle it drains).
// DEPTH must be a power of two so positions wrapping at 2^32 keep their cell.
module tagged_task_ring_queue_core #(
  parameter int DEPTH      = ttrq_pkg::DEPTH_DEFAULT,
  parameter int SLOT_COUNT = ttrq_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // routine[63:0], argument[127:64], task_id[159:128], worker[163:160], pad
  input  logic [ttrq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // mode[2:0]
  input  logic [ttrq_pkg::MODE_W-1:0]     s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_task_id[31:0], out_routine[95:32], out_argument[159:96],
  // out_canceled[160], pad
  output logic [ttrq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // ok[0]
  output logic                            m_axis_tuser
);

  import ttrq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int PAYLOAD_W = 2 * HANDLE_W;

  // request fields
  ttrq_mode_t            in_mode;
  logic [HANDLE_W-1:0]   in_routine;
  logic [HANDLE_W-1:0]   in_argument;
  logic [ID_W-1:0]       in_task_id;
  logic [WORKER_W-1:0]   in_worker;
  logic                  accept;

  // ring positions
  logic [POS_W-1:0]      wpos;
  logic [POS_W-1:0]      rpos;
  logic [POS_W-1:0]      wpos_next;
  logic [POS_W-1:0]      rpos_next;
  logic [POS_W-1:0]      count;
  logic [POS_W-1:0]      qpos;
  logic [POS_W-1:0]      qoff;
  logic                  queued;

  // worker slots
  logic [ID_W-1:0]       slot_ident      [SLOT_COUNT];
  logic                  slot_mark       [SLOT_COUNT];
  logic [ID_W-1:0]       slot_ident_next [SLOT_COUNT];
  logic                  slot_mark_next  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_hit;
  logic [SLOT_COUNT-1:0] slot_first;
  logic                  slot_found;
  logic                  worker_named;

  // cell memories: task payload and cancel mark
  logic [PAYLOAD_W-1:0]  payload_mem [DEPTH];
  logic                  mark_mem    [DEPTH];
  logic [PAYLOAD_W-1:0]  payload_rdata;
  logic                  mark_rdata;
  logic                  payload_we;
  logic [AW-1:0]         payload_waddr;
  logic [PAYLOAD_W-1:0]  payload_wdata;
  logic                  mark_we;
  logic [AW-1:0]         mark_waddr;
  logic                  mark_wdata;
  logic [AW-1:0]         rd_addr;

  // response register
  logic                  out_valid;
  logic                  out_ok;
  logic [ID_W-1:0]       out_task_id;
  logic [HANDLE_W-1:0]   out_routine;
  logic [HANDLE_W-1:0]   out_argument;
  logic                  out_canceled;
  logic                  res_ok;
  logic [ID_W-1:0]       res_task_id;
  logic [HANDLE_W-1:0]   res_routine;
  logic [HANDLE_W-1:0]   res_argument;
  logic                  res_canceled;

  // unpack the request transaction
  assign in_mode     = ttrq_mode_t'(s_axis_tuser);
  assign in_routine  = s_axis_tdata[HANDLE_W-1:0];
  assign in_argument = s_axis_tdata[2*HANDLE_W-1:HANDLE_W];
  assign in_task_id  = s_axis_tdata[2*HANDLE_W+ID_W-1:2*HANDLE_W];
  assign in_worker   = s_axis_tdata[2*HANDLE_W+ID_W+WORKER_W-1:2*HANDLE_W+ID_W];

  assign s_axis_tready = !rst && (!out_valid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // queue occupancy and lookup of a task id among queued positions
  assign count  = wpos - rpos;
  assign qpos   = ~in_task_id;
  assign qoff   = qpos - rpos;
  assign queued = (in_task_id != '0) && (qoff < count);

  assign worker_named = 32'(in_worker) < 32'(SLOT_COUNT);

  // first worker slot that holds the id
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_hit[i]   = slot_ident[i] == in_task_id;
      slot_first[i] = slot_hit[i] && !seen;
      seen          = seen || slot_hit[i];
    end
    slot_found = seen;
  end

  // operation decode, next state and response
  always_comb begin
    wpos_next     = wpos;
    rpos_next     = rpos;
    slot_ident_next = slot_ident;
    slot_mark_next  = slot_mark;
    payload_we    = 1'b0;
    payload_waddr = wpos[AW-1:0];
    payload_wdata = {in_argument, in_routine};
    mark_we       = 1'b0;
    mark_waddr    = wpos[AW-1:0];
    mark_wdata    = 1'b0;
    res_ok        = 1'b0;
    res_task_id   = '0;
    res_routine   = '0;
    res_argument  = '0;
    res_canceled  = 1'b0;
    if (accept) begin
      unique case (in_mode)
        MODE_ENQUEUE: begin
          if (count < 32'(DEPTH)) begin
            payload_we  = 1'b1;
            mark_we     = 1'b1;
            wpos_next   = wpos + 32'd1;
            res_ok      = 1'b1;
            res_task_id = ~wpos;
          end
        end
        MODE_DEQUEUE: begin
          if (count != '0) begin
            rpos_next    = rpos + 32'd1;
            res_ok       = 1'b1;
            res_task_id  = ~rpos;
            res_routine  = payload_rdata[HANDLE_W-1:0];
            res_argument = payload_rdata[PAYLOAD_W-1:HANDLE_W];
            res_canceled = mark_rdata;
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (worker_named && 32'(in_worker) == 32'(i)) begin
                slot_ident_next[i] = ~rpos;
                slot_mark_next[i]  = mark_rdata;
              end
            end
          end
        end
        MODE_CANCEL: begin
          if (queued) begin
            mark_we    = 1'b1;
            mark_waddr = qpos[AW-1:0];
            mark_wdata = 1'b1;
            res_ok     = 1'b1;
          end else if (in_task_id != '0 && slot_found) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (slot_first[i]) begin
                slot_mark_next[i] = 1'b1;
              end
            end
            res_ok = 1'b1;
          end
        end
        MODE_COMPLETED: begin
          res_ok = (in_task_id == '0) || (!queued && !slot_found);
        end
        MODE_READ_FLAG: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (worker_named && 32'(in_worker) == 32'(i)) begin
              res_ok = slot_mark[i];
            end
          end
        end
        MODE_CLEAR: begin
          wpos_next = '0;
          rpos_next = '0;
          res_ok    = 1'b1;
        end
        default: begin
          res_ok = 1'b0;
        end
      endcase
    end
  end

  // prefetch the cell at the next read position
  assign rd_addr = rpos_next[AW-1:0];

  // payload memory with write bypass into the prefetch register
  always_ff @(posedge clk) begin
    if (payload_we) begin
      payload_mem[payload_waddr] <= payload_wdata;
    end
    if (payload_we && payload_waddr == rd_addr) begin
      payload_rdata <= payload_wdata;
    end else begin
      payload_rdata <= payload_mem[rd_addr];
    end
  end

  // cancel mark memory with write bypass
  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    if (mark_we && mark_waddr == rd_addr) begin
      mark_rdata <= mark_wdata;
    end else begin
      mark_rdata <= mark_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wpos      <= '0;
      rpos      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_ident[i] <= '0;
        slot_mark[i]  <= 1'b0;
      end
    end else begin
      wpos       <= wpos_next;
      rpos       <= rpos_next;
      slot_ident <= slot_ident_next;
      slot_mark  <= slot_mark_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // response payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok       <= res_ok;
      out_task_id  <= res_task_id;
      out_routine  <= res_routine;
      out_argument <= res_argument;
      out_canceled <= res_canceled;
    end
  end

  // pack the response transaction
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_ok;
  assign m_axis_tdata  = {{(OUT_DATA_W - ID_W - 2 * HANDLE_W - 1){1'b0}},
                          out_canceled, out_argument, out_routine, out_task_id};

endmodule
